### sv/wst_pkg.sv
`default_nettype none
package wst_pkg;

   localparam int SCREEN_WIDTH = 1024;
   localparam logic signed [65:0] CENTRE_Q = 66'(SCREEN_WIDTH / 2) <<< 16;

   localparam int DIV_STAGES = 62;
   localparam int NUM_W = 62;
   localparam int DEN_W = 32;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EYE_X = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EYE_Y = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EYE_Z = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_YAW = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_YAW = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_PITCH = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_PITCH = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOCAL_LENGTH = 4'd7;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] camera_x;
      logic signed [31:0] camera_y;
      logic signed [31:0] depth;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic depth_zero;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic zero;
      logic neg_x;
      logic neg_y;
   } meta_type;

   function automatic logic signed [39:0] round14(input logic signed [53:0] v);
      logic signed [53:0] t;
      t = v + 54'sd8192;
      return t[53:14];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

### sv/wst_div.sv
`default_nettype none
module wst_div import wst_pkg::*; (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num_in,
   input  wire logic [DEN_W-1:0] den_in,
   output logic      [NUM_W-1:0] quo_out
);

   logic [DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [NUM_W-1:0] nq_ff  [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DEN_W-1:0] prev_rem;
      logic [NUM_W-1:0] prev_nq;
      logic [DEN_W-1:0] prev_den;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      if (s == 0) begin : g_first
         assign prev_rem = '0;
         assign prev_nq  = num_in;
         assign prev_den = den_in;
      end else begin : g_next
         assign prev_rem = rem_ff[s-1];
         assign prev_nq  = nq_ff[s-1];
         assign prev_den = den_ff[s-1];
      end

      always_comb begin
         trial  = {prev_rem, prev_nq[NUM_W-1]};
         diff   = trial - {1'b0, prev_den};
         ge     = (trial >= {1'b0, prev_den});
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         nq_in  = {prev_nq[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            nq_ff[s]  <= nq_in;
            den_ff[s] <= prev_den;
         end
      end
   end

   assign quo_out = nq_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

### sv/world_to_screen_vertex_transform.sv
// channel  | ports                                   | direction
// req      | req_valid req_stall req_payload         | vertex in
// rsp      | rsp_valid rsp_stall rsp_payload         | camera and screen coordinates out
// csr      | csr_valid csr_ready csr_index csr_data  | register writes
// one vertex per cycle while no result is stalled; 7 transform stages, 62 divider stages, output register
// the divider, one quotient bit per stage, sets the depth of the pipeline
// synchronous reset clears the valid bits and loads the register defaults
// a stalled result holds the whole pipeline; req_stall follows it
`default_nettype none
module world_to_screen_vertex_transform import wst_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);

   logic signed [31:0] eye_x_ff, eye_y_ff, eye_z_ff;
   logic signed [15:0] cos_yaw_ff, sin_yaw_ff, cos_pitch_ff, sin_pitch_ff;
   logic [30:0]        focal_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff     <= '0;
         eye_y_ff     <= '0;
         eye_z_ff     <= '0;
         cos_yaw_ff   <= 16'sd16384;
         sin_yaw_ff   <= '0;
         cos_pitch_ff <= 16'sd16384;
         sin_pitch_ff <= '0;
         focal_ff     <= 31'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EYE_X:        eye_x_ff     <= csr_data;
            CSR_EYE_Y:        eye_y_ff     <= csr_data;
            CSR_EYE_Z:        eye_z_ff     <= csr_data;
            CSR_COS_YAW:      cos_yaw_ff   <= csr_data[15:0];
            CSR_SIN_YAW:      sin_yaw_ff   <= csr_data[15:0];
            CSR_COS_PITCH:    cos_pitch_ff <= csr_data[15:0];
            CSR_SIN_PITCH:    sin_pitch_ff <= csr_data[15:0];
            CSR_FOCAL_LENGTH: focal_ff     <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic req_take;
   logic [6:0] pv_ff;
   logic dv_ff [DIV_STAGES];
   logic rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign req_take  = req_valid && !req_stall;

   // stage 1: offsets
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   // stage 2: yaw products
   logic signed [48:0] yxa_ff, yxb_ff, yza_ff, yzb_ff;
   logic signed [32:0] dy2_ff;
   // stage 3: yaw sums
   logic signed [35:0] cx3_ff, z1_ff;
   logic signed [32:0] dy3_ff;
   // stage 4: pitch products
   logic signed [48:0] pa_ff, pd_ff;
   logic signed [51:0] pb_ff, pc_ff;
   logic signed [35:0] cx4_ff;
   // stage 5: camera space
   logic signed [31:0] cx5_ff, cy5_ff, cz5_ff;
   // stage 6: numerators
   logic signed [63:0] prodx_ff, prody_ff;
   logic signed [31:0] cx6_ff, cy6_ff, cz6_ff;
   // stage 7: magnitudes
   logic [NUM_W-1:0] magx_ff, magy_ff;
   logic [DEN_W-1:0] dmag_ff;
   meta_type meta7_ff;
   meta_type meta_ff [DIV_STAGES];

   logic signed [39:0] r_cx, r_z1, r_cy, r_cz;
   logic signed [63:0] negx_w, negy_w;
   logic signed [31:0] negz_w;

   always_comb begin
      r_cx   = round14(54'(50'(yxa_ff) - 50'(yxb_ff)));
      r_z1   = round14(54'(50'(yza_ff) + 50'(yzb_ff)));
      r_cy   = round14(54'(pa_ff) + 54'(pb_ff));
      r_cz   = round14(54'(pc_ff) - 54'(pd_ff));
      negx_w = -prodx_ff;
      negy_w = -prody_ff;
      negz_w = -cz6_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= {req_payload.world_x[31], req_payload.world_x} - {eye_x_ff[31], eye_x_ff};
         dy_ff <= {req_payload.world_y[31], req_payload.world_y} - {eye_y_ff[31], eye_y_ff};
         dz_ff <= {req_payload.world_z[31], req_payload.world_z} - {eye_z_ff[31], eye_z_ff};

         yxa_ff <= cos_yaw_ff * dx_ff;
         yxb_ff <= sin_yaw_ff * dz_ff;
         yza_ff <= sin_yaw_ff * dx_ff;
         yzb_ff <= cos_yaw_ff * dz_ff;
         dy2_ff <= dy_ff;

         cx3_ff <= r_cx[35:0];
         z1_ff  <= r_z1[35:0];
         dy3_ff <= dy2_ff;

         pa_ff  <= cos_pitch_ff * dy3_ff;
         pb_ff  <= sin_pitch_ff * z1_ff;
         pc_ff  <= cos_pitch_ff * z1_ff;
         pd_ff  <= sin_pitch_ff * dy3_ff;
         cx4_ff <= cx3_ff;

         cx5_ff <= sat32(66'(cx4_ff));
         cy5_ff <= sat32(66'(r_cy));
         cz5_ff <= sat32(66'(r_cz));

         prodx_ff <= $signed({1'b0, focal_ff}) * cx5_ff;
         prody_ff <= $signed({1'b0, focal_ff}) * cy5_ff;
         cx6_ff   <= cx5_ff;
         cy6_ff   <= cy5_ff;
         cz6_ff   <= cz5_ff;

         magx_ff        <= prodx_ff[63] ? negx_w[NUM_W-1:0] : prodx_ff[NUM_W-1:0];
         magy_ff        <= prody_ff[63] ? negy_w[NUM_W-1:0] : prody_ff[NUM_W-1:0];
         dmag_ff        <= cz6_ff[31] ? negz_w : cz6_ff;
         meta7_ff.cx    <= cx6_ff;
         meta7_ff.cy    <= cy6_ff;
         meta7_ff.cz    <= cz6_ff;
         meta7_ff.zero  <= (cz6_ff == 32'sd0);
         meta7_ff.neg_x <= prodx_ff[63] ^ cz6_ff[31];
         meta7_ff.neg_y <= prody_ff[63] ^ cz6_ff[31];
      end
   end

   logic [NUM_W-1:0] qx, qy;

   wst_div u_div_x (
      .clock   (clock),
      .en      (en),
      .num_in  (magx_ff),
      .den_in  (dmag_ff),
      .quo_out (qx)
   );

   wst_div u_div_y (
      .clock   (clock),
      .en      (en),
      .num_in  (magy_ff),
      .den_in  (dmag_ff),
      .quo_out (qy)
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            meta_ff[s] <= (s == 0) ? meta7_ff : meta_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (en) begin
            dv_ff[s] <= (s == 0) ? pv_ff[6] : dv_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         pv_ff        <= {pv_ff[5:0], req_take};
         rsp_valid_ff <= dv_ff[DIV_STAGES-1];
      end
   end

   meta_type mo;
   logic signed [63:0] qx_s, qy_s;
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      mo   = meta_ff[DIV_STAGES-1];
      qx_s = mo.neg_x ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
      qy_s = mo.neg_y ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
      rsp_in.camera_x   = mo.cx;
      rsp_in.camera_y   = mo.cy;
      rsp_in.depth      = mo.cz;
      rsp_in.depth_zero = mo.zero;
      if (mo.zero) begin
         rsp_in.screen_x = sat32(CENTRE_Q);
         rsp_in.screen_y = sat32(CENTRE_Q);
      end else begin
         rsp_in.screen_x = sat32(66'(qx_s) + CENTRE_Q);
         rsp_in.screen_y = sat32(66'(qy_s) + CENTRE_Q);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.depth_zero == (rsp_payload.depth == 32'sd0)))
      else $error("depth_zero flag disagrees with depth");

   a_take_enters: assert property (@(posedge clock) disable iff (reset)
      req_take |=> pv_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (en && dv_ff[DIV_STAGES-1]) |=> rsp_valid)
      else $error("divider output lost before the output register");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(pv_ff) && rsp_valid))
      else $error("pipeline moved while the result was stalled");

endmodule
`default_nettype wire
